### src/jvcs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jvcs_pkg: shared definitions for the joint velocity command shaper
// Widths, register indexes, reset values, status codes and sequencer states.
// ---------------------------------------------------------------------------
package jvcs_pkg;

	localparam int JOINT_COUNT     = 7;
	localparam int PROXIMAL_JOINTS = 4;
	localparam int JIDX_W          = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

	localparam int VEL_W    = 20;   // signed velocity, 12 fraction bits
	localparam int LIMIT_W  = 15;
	localparam int FRAC_W   = 17;   // Q16 fractions up to and including one
	localparam int TICK_W   = 16;
	localparam int STATUS_W = 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam int TDATA_W = ((JOINT_COUNT * VEL_W + 7) / 8) * 8;
	localparam int TUSER_IN_W = 2;

	// shared multiplier: signed (VEL_W+1) x signed (FRAC_W+1)
	localparam int MUL_A_W = VEL_W + 1;
	localparam int MUL_B_W = FRAC_W + 1;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// dividend of the limit scaling divide: |c| * limit + den/2
	localparam int DVD_W   = VEL_W + LIMIT_W + 1;
	localparam int DCNT_W  = $clog2(VEL_W);

	localparam logic [FRAC_W-1:0] ONE_Q16    = FRAC_W'(65536);
	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);
	localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};

	localparam logic [LIMIT_W-1:0] LIMIT_PROXIMAL_RST = LIMIT_W'(10719);
	localparam logic [LIMIT_W-1:0] LIMIT_DISTAL_RST   = LIMIT_W'(21516);
	localparam logic [FRAC_W-1:0]  RAMP_STEP_RST      = FRAC_W'(131);
	localparam logic [TICK_W-1:0]  TIMEOUT_TICKS_RST  = TICK_W'(500);
	localparam logic [FRAC_W-1:0]  SMOOTH_WEIGHT_RST  = FRAC_W'(9830);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LIMIT_PROXIMAL = 3'd0,
		REG_LIMIT_DISTAL   = 3'd1,
		REG_RAMP_STEP      = 3'd2,
		REG_TIMEOUT_TICKS  = 3'd3,
		REG_SMOOTH_WEIGHT  = 3'd4
	} cfg_reg_t;

	typedef enum logic [STATUS_W-1:0] {
		STOP_NONE     = 2'd0,
		STOP_WATCHDOG = 2'd1,
		STOP_SOLVER   = 2'd2
	} stop_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RAMP_MUL,
		ST_RAMP_WB,
		ST_FIND_A,
		ST_FIND_B,
		ST_FIND_CMP,
		ST_SCL_MUL,
		ST_SCL_INIT,
		ST_SCL_DIV,
		ST_SCL_WB,
		ST_SMO_A,
		ST_SMO_B,
		ST_SMO_WB,
		ST_DONE
	} state_t;

endpackage

### src/joint_velocity_command_shaper_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// joint_velocity_command_shaper_unit: per-tick joint velocity shaping
// Watchdog, solver-failure stop, start-up ramp, common limit scaling and
// exponential smoothing, all on one shared multiplier and a radix-2 divider.
// ---------------------------------------------------------------------------
// Sequence: a stop tick goes from ST_IDLE straight to ST_DONE; a normal tick
//   runs a ramp pass, a limit search pass and a smoothing pass over the joints,
//   with a scaling pass (20-step divide per joint) before smoothing when scaling engages.
// One word at a time: a new tick is taken only after the last word has moved to
//   the output register. The divider gives one quotient bit per cycle.
// Reset: registers take their reset values, ramp, watchdog and smoother clear.
module joint_velocity_command_shaper_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// slave side
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [jvcs_pkg::TDATA_W-1:0]    s_axis_tdata,  // vel_in_0 .. vel_in_6, zero pad
	input  logic [jvcs_pkg::TUSER_IN_W-1:0] s_axis_tuser,  // target_seen, solver_failed
	// master side
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [jvcs_pkg::TDATA_W-1:0]    m_axis_tdata,  // vel_out_0 .. vel_out_6, zero pad
	output logic [jvcs_pkg::STATUS_W-1:0]   m_axis_tuser,  // stop_status
	// configuration
	input  logic                            cfg_we,
	input  logic [jvcs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [jvcs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import jvcs_pkg::*;

	// configuration registers
	logic [LIMIT_W-1:0] limit_prox_q, limit_dist_q;
	logic [FRAC_W-1:0]  ramp_step_q, smooth_weight_q;
	logic [TICK_W-1:0]  timeout_q;

	// tick state
	logic [FRAC_W-1:0]       ramp_q;
	logic [TICK_W-1:0]       ticks_q;
	logic signed [VEL_W-1:0] prev_q [JOINT_COUNT];

	// working set
	state_t                    state_q, state_nx;
	logic signed [VEL_W-1:0]   vel_q [JOINT_COUNT];
	logic signed [MUL_A_W-1:0] cmd_q [JOINT_COUNT];
	logic [JOINT_COUNT-1:0]    over_q;
	logic signed [VEL_W-1:0]   res_q [JOINT_COUNT];
	stop_t                     res_stat_q;
	logic [JIDX_W-1:0]         idx_q;
	logic [DCNT_W-1:0]         dcnt_q;
	logic                      found_q;
	logic [VEL_W-1:0]          den_q;
	logic [LIMIT_W-1:0]        numer_q;
	logic signed [PROD_W-1:0]  prod_q, hold_q;
	logic [VEL_W-1:0]          rem_q, dvd_q, quo_q;

	// output register
	logic                      out_valid_q;
	logic signed [VEL_W-1:0]   out_vel_q [JOINT_COUNT];
	stop_t                     out_stat_q;

	// combinational
	logic                      in_acc, out_free, out_load, idx_last, div_last;
	logic [TICK_W-1:0]         ticks_nx;
	logic                      wd_stop;
	logic [FRAC_W:0]           ramp_sum;
	logic [FRAC_W-1:0]         ramp_nx, w_eff, w_rest;
	logic [LIMIT_W-1:0]        lim_cur;
	logic [VEL_W-1:0]          vel_abs, cmd_abs;
	logic signed [VEL_W-1:0]   vel_cur;
	logic signed [MUL_A_W-1:0] cmd_cur, cmd_neg;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic [VEL_W+15:0]         ramp_rnd;
	logic [VEL_W-1:0]          ramp_r;
	logic                      find_hit, found_nx;
	logic [DVD_W-1:0]          div_dividend;
	logic [VEL_W:0]            div_trial, div_diff;
	logic                      div_ge;
	logic signed [PROD_W:0]    smo_sum, smo_neg;
	logic [PROD_W-1:0]         smo_abs, smo_rnd;
	logic [VEL_W:0]            smo_r, smo_rneg;
	logic signed [VEL_W-1:0]   smo_y;
	logic                      prev_zero;

	// ------------------------------------------------------------------
	// small datapath helpers
	// ------------------------------------------------------------------
	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign idx_last = (idx_q == JIDX_W'(JOINT_COUNT - 1));
	assign div_last = (dcnt_q == DCNT_W'(VEL_W - 1));

	assign ticks_nx = s_axis_tuser[0] ? '0 :
		((ticks_q == '1) ? ticks_q : ticks_q + 1'b1);
	assign wd_stop  = ticks_nx > timeout_q;

	assign ramp_sum = {1'b0, ramp_q} + {1'b0, ramp_step_q};
	assign ramp_nx  = (ramp_sum > {1'b0, ONE_Q16}) ? ONE_Q16 : ramp_sum[FRAC_W-1:0];

	assign w_eff  = (smooth_weight_q > ONE_Q16) ? ONE_Q16 : smooth_weight_q;
	assign w_rest = ONE_Q16 - w_eff;

	assign lim_cur = (idx_q < JIDX_W'(PROXIMAL_JOINTS)) ? limit_prox_q : limit_dist_q;

	always_comb begin
		vel_cur = vel_q[idx_q];
		vel_abs = vel_cur[VEL_W-1] ? VEL_W'(-vel_cur) : vel_cur;
		cmd_cur = cmd_q[idx_q];
		cmd_neg = -cmd_cur;
		cmd_abs = cmd_cur[MUL_A_W-1] ? cmd_neg[VEL_W-1:0] : cmd_cur[VEL_W-1:0];
	end

	// ramp product rounding, ties away from zero on the magnitude
	assign ramp_rnd = prod_q[VEL_W+15:0] + (VEL_W+16)'(ROUND_HALF);
	assign ramp_r   = ramp_rnd[VEL_W+15:16];

	// smaller limit/|c| wins: lim_i * |c_w| < lim_w * |c_i|
	assign find_hit = over_q[idx_q] && (!found_q || (hold_q < prod_q));
	assign found_nx = found_q || find_hit;

	assign div_dividend = DVD_W'(prod_q[DVD_W-2:0]) + DVD_W'(den_q >> 1);
	assign div_trial    = {rem_q, dvd_q[VEL_W-1]};
	assign div_ge       = div_trial >= {1'b0, den_q};
	assign div_diff     = div_trial - {1'b0, den_q};

	always_comb begin
		smo_sum  = hold_q + prod_q;
		smo_neg  = -smo_sum;
		smo_abs  = smo_sum[PROD_W] ? smo_neg[PROD_W-1:0] : smo_sum[PROD_W-1:0];
		smo_rnd  = smo_abs + ROUND_HALF;
		smo_r    = smo_rnd[VEL_W+16:16];
		smo_rneg = -smo_r;
		if (smo_sum[PROD_W])
			smo_y = smo_rneg[VEL_W-1:0];
		else if (smo_r > {1'b0, VEL_MAX})
			smo_y = VEL_MAX;
		else
			smo_y = smo_r[VEL_W-1:0];
	end

	always_comb begin
		prev_zero = 1'b1;
		for (int i = 0; i < JOINT_COUNT; i++) begin
			if (prev_q[i] != '0)
				prev_zero = 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// sequencer: next state
	// ------------------------------------------------------------------
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (wd_stop || s_axis_tuser[1])
						state_nx = ST_DONE;
					else
						state_nx = ST_RAMP_MUL;
				end
			end
			ST_RAMP_MUL: state_nx = ST_RAMP_WB;
			ST_RAMP_WB:  state_nx = idx_last ? ST_FIND_A : ST_RAMP_MUL;
			ST_FIND_A:   state_nx = ST_FIND_B;
			ST_FIND_B:   state_nx = ST_FIND_CMP;
			ST_FIND_CMP: begin
				if (!idx_last)
					state_nx = ST_FIND_A;
				else if (found_nx)
					state_nx = ST_SCL_MUL;
				else
					state_nx = ST_SMO_A;
			end
			ST_SCL_MUL:  state_nx = ST_SCL_INIT;
			ST_SCL_INIT: state_nx = ST_SCL_DIV;
			ST_SCL_DIV:  state_nx = div_last ? ST_SCL_WB : ST_SCL_DIV;
			ST_SCL_WB:   state_nx = idx_last ? ST_SMO_A : ST_SCL_MUL;
			ST_SMO_A:    state_nx = ST_SMO_B;
			ST_SMO_B:    state_nx = ST_SMO_WB;
			ST_SMO_WB:   state_nx = idx_last ? ST_DONE : ST_SMO_A;
			ST_DONE:     state_nx = out_free ? ST_IDLE : ST_DONE;
			default:     state_nx = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// sequencer: outputs and multiplier operand select
	// ------------------------------------------------------------------
	always_comb begin
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		mul_a         = '0;
		mul_b         = '0;
		case (state_q)
			ST_IDLE:     s_axis_tready = 1'b1;
			ST_RAMP_MUL: begin
				mul_a = MUL_A_W'(vel_abs);
				mul_b = MUL_B_W'(ramp_q);
			end
			ST_FIND_A: begin
				mul_a = MUL_A_W'(den_q);
				mul_b = MUL_B_W'(lim_cur);
			end
			ST_FIND_B: begin
				mul_a = MUL_A_W'(cmd_abs);
				mul_b = MUL_B_W'(numer_q);
			end
			ST_SCL_MUL: begin
				mul_a = MUL_A_W'(cmd_abs);
				mul_b = MUL_B_W'(numer_q);
			end
			ST_SMO_A: begin
				mul_a = cmd_cur;
				mul_b = MUL_B_W'(w_eff);
			end
			ST_SMO_B: begin
				mul_a = MUL_A_W'(prev_q[idx_q]);
				mul_b = MUL_B_W'(w_rest);
			end
			ST_DONE:     out_load = out_free;
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			out_valid_q     <= 1'b0;
			limit_prox_q    <= LIMIT_PROXIMAL_RST;
			limit_dist_q    <= LIMIT_DISTAL_RST;
			ramp_step_q     <= RAMP_STEP_RST;
			timeout_q       <= TIMEOUT_TICKS_RST;
			smooth_weight_q <= SMOOTH_WEIGHT_RST;
			ramp_q          <= '0;
			ticks_q         <= '0;
			for (int i = 0; i < JOINT_COUNT; i++)
				prev_q[i] <= '0;
			idx_q           <= '0;
			dcnt_q          <= '0;
			found_q         <= 1'b0;
		end else begin
			state_q <= state_nx;

			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_LIMIT_PROXIMAL: limit_prox_q    <= cfg_data[LIMIT_W-1:0];
					REG_LIMIT_DISTAL:   limit_dist_q    <= cfg_data[LIMIT_W-1:0];
					REG_RAMP_STEP:      ramp_step_q     <= cfg_data[FRAC_W-1:0];
					REG_TIMEOUT_TICKS:  timeout_q       <= cfg_data[TICK_W-1:0];
					REG_SMOOTH_WEIGHT:  smooth_weight_q <= cfg_data[FRAC_W-1:0];
					default: ;
				endcase
			end

			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (in_acc) begin
						ticks_q <= ticks_nx;
						if (wd_stop) begin
							for (int i = 0; i < JOINT_COUNT; i++)
								prev_q[i] <= '0;
						end else if (!s_axis_tuser[1]) begin
							ramp_q <= ramp_nx;
						end
					end
				end
				ST_RAMP_WB: idx_q <= idx_last ? '0 : idx_q + 1'b1;
				ST_FIND_A: begin
					if (idx_q == '0)
						found_q <= 1'b0;
				end
				ST_FIND_CMP: begin
					found_q <= found_nx;
					idx_q   <= idx_last ? '0 : idx_q + 1'b1;
				end
				ST_SCL_INIT: dcnt_q <= '0;
				ST_SCL_DIV:  dcnt_q <= dcnt_q + 1'b1;
				ST_SCL_WB:   idx_q  <= idx_last ? '0 : idx_q + 1'b1;
				ST_SMO_WB: begin
					prev_q[idx_q] <= smo_y;
					idx_q         <= idx_last ? '0 : idx_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;

		if (out_load) begin
			for (int i = 0; i < JOINT_COUNT; i++)
				out_vel_q[i] <= res_q[i];
			out_stat_q <= res_stat_q;
		end

		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					for (int i = 0; i < JOINT_COUNT; i++) begin
						vel_q[i] <= s_axis_tdata[i*VEL_W +: VEL_W];
						res_q[i] <= '0;
					end
					if (wd_stop)
						res_stat_q <= STOP_WATCHDOG;
					else if (s_axis_tuser[1])
						res_stat_q <= STOP_SOLVER;
					else
						res_stat_q <= STOP_NONE;
				end
			end
			ST_RAMP_WB: begin
				cmd_q[idx_q]  <= vel_cur[VEL_W-1] ? -MUL_A_W'(ramp_r) : MUL_A_W'(ramp_r);
				over_q[idx_q] <= ramp_r > VEL_W'(lim_cur);
			end
			ST_FIND_B: hold_q <= prod_q;
			ST_FIND_CMP: begin
				if (find_hit) begin
					den_q   <= cmd_abs;
					numer_q <= lim_cur;
				end
			end
			ST_SCL_INIT: begin
				rem_q <= VEL_W'(div_dividend >> VEL_W);
				dvd_q <= div_dividend[VEL_W-1:0];
				quo_q <= '0;
			end
			ST_SCL_DIV: begin
				rem_q <= div_ge ? div_diff[VEL_W-1:0] : div_trial[VEL_W-1:0];
				dvd_q <= {dvd_q[VEL_W-2:0], 1'b0};
				quo_q <= {quo_q[VEL_W-2:0], div_ge};
			end
			ST_SCL_WB: begin
				cmd_q[idx_q] <= cmd_cur[MUL_A_W-1] ? -MUL_A_W'(quo_q) : MUL_A_W'(quo_q);
			end
			ST_SMO_B:  hold_q <= prod_q;
			ST_SMO_WB: res_q[idx_q] <= smo_y;
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// ports
	// ------------------------------------------------------------------
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_stat_q;

	always_comb begin
		m_axis_tdata = '0;
		for (int i = 0; i < JOINT_COUNT; i++)
			m_axis_tdata[i*VEL_W +: VEL_W] = out_vel_q[i];
	end

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_ramp_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		ramp_q <= ONE_Q16)
		else $error("ramp level above one");

	a_watchdog_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && wd_stop) |=> prev_zero)
		else $error("smoother memory not cleared on watchdog stop");

	a_scale_needs_worst: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCL_MUL) |-> found_q)
		else $error("limit scaling without a joint over its limit");

	a_div_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCL_DIV) |-> (den_q != '0))
		else $error("divide by zero magnitude");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (m_axis_tvalid && state_q == ST_IDLE))
		else $error("finished word not presented");

endmodule

### test/joint_velocity_command_shaper_unit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// joint_velocity_command_shaper_unit_test: self-checking bench for the shaper
// A short directed table, then randomized phases with new register settings
// between them. Every output word is checked against an in-bench model of
// the watchdog, ramp, limit scaling and smoothing chain, or a typed-in word.
// ---------------------------------------------------------------------------
module joint_velocity_command_shaper_unit_test;

	import jvcs_pkg::*;

	localparam int VMAX            = 524287;
	localparam int VMIN            = -524288;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 130;
	localparam int HOLD_CYCLES     = 400;
	localparam int LIMIT_CYCLES    = 1200000;

	typedef logic [JOINT_COUNT-1:0][VEL_W-1:0] joint_vec_t;

	typedef struct packed {
		logic       solver_failed;
		logic       target_seen;
		joint_vec_t vel;
	} tick_t;

	typedef struct packed {
		stop_t      status;
		joint_vec_t vel;
	} shaped_t;

	typedef enum logic {ROW_TICK, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		tick_t       t;
		logic        typed;        // expected word typed in: all joints zero
		stop_t       typed_status;
		cfg_reg_t    idx;
		int unsigned val;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [TDATA_W-1:0]    s_axis_tdata;
	logic [TUSER_IN_W-1:0] s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [TDATA_W-1:0]    m_axis_tdata;
	logic [STATUS_W-1:0]   m_axis_tuser;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// shadow of the block: registers and state
	longint cfg_limit_prox;
	longint cfg_limit_dist;
	longint cfg_ramp_step;
	longint cfg_timeout;
	longint cfg_weight;
	longint ramp_q16;
	longint idle_ticks;
	longint prev_cmd[JOINT_COUNT];

	shaped_t   shaped_q[$];
	plan_row_t plan_q[$];
	int        errors;
	int        words_seen;
	int        cycle_count;
	int        burst_left;
	int        gap_max;
	bit        hold_req;
	bit        rx_quiet;

	joint_velocity_command_shaper_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint q16_round(input longint x);
		if (x >= 0)
			return (x + 32768) >>> 16;
		return -(((-x) + 32768) >>> 16);
	endfunction

	function automatic longint magnitude(input longint x);
		return (x < 0) ? -x : x;
	endfunction

	function automatic shaped_t shape_tick(input tick_t t);
		shaped_t r;
		longint  c[JOINT_COUNT];
		longint  lim[JOINT_COUNT];
		longint  den, num, q, w, y;
		int      worst;
		r.vel = '0;
		r.status = STOP_NONE;
		if (t.target_seen)
			idle_ticks = 0;
		else if (idle_ticks < 65535)
			idle_ticks++;
		// watchdog wins over solver failure and clears the smoother
		if (idle_ticks > cfg_timeout) begin
			for (int j = 0; j < JOINT_COUNT; j++)
				prev_cmd[j] = 0;
			r.status = STOP_WATCHDOG;
			return r;
		end
		if (t.solver_failed) begin
			r.status = STOP_SOLVER;
			return r;
		end
		ramp_q16 = ramp_q16 + cfg_ramp_step;
		if (ramp_q16 > 65536)
			ramp_q16 = 65536;
		worst = -1;
		for (int j = 0; j < JOINT_COUNT; j++) begin
			c[j] = q16_round(longint'($signed(t.vel[j])) * ramp_q16);
			lim[j] = (j < PROXIMAL_JOINTS) ? cfg_limit_prox : cfg_limit_dist;
			// cross-multiplied ratio compare, first joint kept on ties
			if (magnitude(c[j]) > lim[j])
				if (worst < 0 || lim[j] * magnitude(c[worst]) < lim[worst] * magnitude(c[j]))
					worst = j;
		end
		if (worst >= 0) begin
			den = magnitude(c[worst]);
			num = lim[worst];
			for (int j = 0; j < JOINT_COUNT; j++) begin
				q = (magnitude(c[j]) * num + den / 2) / den;
				c[j] = (c[j] < 0) ? -q : q;
			end
		end
		w = (cfg_weight > 65536) ? 65536 : cfg_weight;
		for (int j = 0; j < JOINT_COUNT; j++) begin
			y = q16_round(w * c[j] + (65536 - w) * prev_cmd[j]);
			if (y > VMAX)
				y = VMAX;
			if (y < VMIN)
				y = VMIN;
			prev_cmd[j] = y;
			r.vel[j] = VEL_W'(y);
		end
		return r;
	endfunction

	function automatic joint_vec_t vec7(input int a0, input int a1, input int a2, input int a3,
			input int a4, input int a5, input int a6);
		joint_vec_t v;
		v[0] = VEL_W'(a0);
		v[1] = VEL_W'(a1);
		v[2] = VEL_W'(a2);
		v[3] = VEL_W'(a3);
		v[4] = VEL_W'(a4);
		v[5] = VEL_W'(a5);
		v[6] = VEL_W'(a6);
		return v;
	endfunction

	function automatic tick_t random_tick(input int target_pct, input int fail_pct);
		tick_t t;
		int    span;
		span = 1 << $urandom_range(4, 16);
		for (int j = 0; j < JOINT_COUNT; j++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: t.vel[j] = VEL_W'($urandom);
				4, 5, 6, 7, 8: t.vel[j] = VEL_W'(int'($urandom_range(0, 2 * span)) - span);
				default: begin
					case ($urandom_range(0, 3))
						0: t.vel[j] = VEL_W'(VMAX);
						1: t.vel[j] = VEL_W'(VMIN);
						2: t.vel[j] = '0;
						default: t.vel[j] = '1;
					endcase
				end
			endcase
		end
		t.target_seen = ($urandom_range(0, 99) < target_pct);
		t.solver_failed = ($urandom_range(0, 99) < fail_pct);
		return t;
	endfunction

	function automatic int pick_cfg(input int lo, input int hi);
		case ($urandom_range(0, 3))
			0: return lo;
			1: return hi;
			default: return $urandom_range(lo, hi);
		endcase
	endfunction

	task automatic plan_tick(input joint_vec_t v, input logic tgt, input logic fail,
			input logic typed, input stop_t st);
		plan_row_t row;
		row.kind = ROW_TICK;
		row.t.vel = v;
		row.t.target_seen = tgt;
		row.t.solver_failed = fail;
		row.typed = typed;
		row.typed_status = st;
		row.idx = REG_LIMIT_PROXIMAL;
		row.val = 0;
		plan_q.insert(plan_q.size(), row);
	endtask

	task automatic plan_reg(input cfg_reg_t idx, input int unsigned val);
		plan_row_t row;
		row.kind = ROW_REG;
		row.t = '0;
		row.typed = 1'b0;
		row.typed_status = STOP_NONE;
		row.idx = idx;
		row.val = val;
		plan_q.insert(plan_q.size(), row);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_LIMIT_PROXIMAL: cfg_limit_prox = val & 32'h7FFF;
			REG_LIMIT_DISTAL: cfg_limit_dist = val & 32'h7FFF;
			REG_RAMP_STEP: cfg_ramp_step = val & 32'h1FFFF;
			REG_TIMEOUT_TICKS: cfg_timeout = val & 32'hFFFF;
			REG_SMOOTH_WEIGHT: cfg_weight = val & 32'h1FFFF;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// sender stops and waits until every expected word is out
	task automatic wait_for_results;
		s_axis_tvalid <= 1'b0;
		while (shaped_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic offer_tick(input tick_t t, input logic typed, input stop_t st);
		shaped_t want;
		if (burst_left == 0) begin
			if (gap_max > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, gap_max)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= TDATA_W'(t.vel);
		s_axis_tuser <= {t.solver_failed, t.target_seen};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		want = shape_tick(t);
		if (typed) begin
			want.vel = '0;
			want.status = st;
		end
		shaped_q.insert(shaped_q.size(), want);
	endtask

	task automatic report_mismatch(input string field, input longint got, input longint want);
		if (errors < 40)
			$display("%0t word %0d: %s got %0d, expected %0d", $time, words_seen, field, got, want);
		errors++;
	endtask

	always @(posedge clk) begin : result_check
		shaped_t got;
		shaped_t want;
		int      bad;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.vel = m_axis_tdata[JOINT_COUNT*VEL_W-1:0];
			got.status = stop_t'(m_axis_tuser);
			if (shaped_q.size() == 0) begin
				report_mismatch("word with none pending, stop_status", got.status, -1);
			end else begin
				want = shaped_q.pop_front();
				bad = -1;
				for (int j = JOINT_COUNT - 1; j >= 0; j--)
					if (got.vel[j] !== want.vel[j])
						bad = j;
				if (got.status !== want.status)
					report_mismatch("stop_status", got.status, want.status);
				if (bad >= 0)
					report_mismatch($sformatf("vel_out_%0d", bad), $signed(got.vel[bad]),
						$signed(want.vel[bad]));
			end
			words_seen++;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver: own stall pattern, plus one long hold-off on request
	initial begin
		m_axis_tready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (rx_quiet) begin
				m_axis_tready <= 1'b1;
				repeat (20) @(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	initial begin
		int target_pct;
		int fail_pct;
		int tmo;
		errors = 0;
		words_seen = 0;
		cycle_count = 0;
		burst_left = 0;
		gap_max = 4;
		hold_req = 1'b0;
		rx_quiet = 1'b0;
		cfg_limit_prox = LIMIT_PROXIMAL_RST;
		cfg_limit_dist = LIMIT_DISTAL_RST;
		cfg_ramp_step = RAMP_STEP_RST;
		cfg_timeout = TIMEOUT_TICKS_RST;
		cfg_weight = SMOOTH_WEIGHT_RST;
		ramp_q16 = 0;
		idle_ticks = 0;
		for (int j = 0; j < JOINT_COUNT; j++)
			prev_cmd[j] = 0;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;

		// reset settings, ramp just starting
		plan_tick(vec7(0, 0, 0, 0, 0, 0, 0), 1, 0, 1, STOP_NONE);
		plan_tick(vec7(VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX), 1, 1, 1, STOP_SOLVER);
		plan_tick(vec7(VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX), 1, 0, 0, STOP_NONE);
		plan_tick(vec7(VMIN, VMIN, VMIN, VMIN, VMIN, VMIN, VMIN), 1, 0, 0, STOP_NONE);
		plan_tick(vec7(VMAX, VMIN, 1, -1, 0, VMAX, VMIN), 1, 0, 0, STOP_NONE);
		plan_tick(vec7(VMIN, VMAX, -1, 1, 0, VMIN, VMAX), 0, 1, 1, STOP_SOLVER);
		plan_reg(REG_RAMP_STEP, 0);
		plan_tick(vec7(12345, -2345, 345, -45, 5, 99999, -99999), 1, 0, 0, STOP_NONE);
		// wide limits, pass-through smoother, one-tick watchdog
		plan_reg(REG_TIMEOUT_TICKS, 1);
		plan_reg(REG_RAMP_STEP, 3000);
		plan_reg(REG_SMOOTH_WEIGHT, 65536);
		plan_reg(REG_LIMIT_PROXIMAL, 32767);
		plan_reg(REG_LIMIT_DISTAL, 32767);
		plan_tick(vec7(VMAX, VMIN, 100000, -100000, 200000, -300000, 50000), 1, 0, 0, STOP_NONE);
		plan_tick(vec7(1000, -1000, 2000, -2000, 3000, -3000, 4000), 0, 0, 0, STOP_NONE);
		plan_tick(vec7(VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX), 0, 0, 1, STOP_WATCHDOG);
		plan_tick(vec7(VMIN, VMIN, VMIN, VMIN, VMIN, VMIN, VMIN), 0, 1, 1, STOP_WATCHDOG);
		plan_tick(vec7(VMIN, VMIN, VMIN, VMIN, VMIN, VMIN, VMIN), 1, 1, 1, STOP_SOLVER);
		plan_tick(vec7(40000, -40000, 7, -7, 65000, -65000, 0), 1, 0, 0, STOP_NONE);
		// zero limits: any nonzero command zeroes the tick; smoother holds
		plan_reg(REG_LIMIT_PROXIMAL, 0);
		plan_reg(REG_LIMIT_DISTAL, 0);
		plan_reg(REG_SMOOTH_WEIGHT, 0);
		plan_tick(vec7(500, -500, 0, 0, 0, 0, 900), 1, 0, 0, STOP_NONE);
		plan_tick(vec7(0, 0, 0, 0, 0, 0, 0), 1, 0, 0, STOP_NONE);
		plan_reg(REG_LIMIT_PROXIMAL, 1000);
		plan_reg(REG_LIMIT_DISTAL, 20000);
		plan_reg(REG_SMOOTH_WEIGHT, 32768);
		plan_reg(REG_TIMEOUT_TICKS, 65535);
		// equal worst ratios on two joints, then proximal and distal joints over their limits
		plan_tick(vec7(VMAX, VMAX, 0, 0, 0, 0, 0), 1, 0, 0, STOP_NONE);
		plan_tick(vec7(30000, 0, 0, 0, VMAX, VMIN, 0), 1, 0, 0, STOP_NONE);
		plan_tick(vec7(-3, 3, -1, 1, -5, 5, 0), 1, 0, 0, STOP_NONE);
		plan_tick(vec7(VMIN, VMIN, VMIN, VMIN, VMIN, VMIN, VMIN), 1, 0, 0, STOP_NONE);
		plan_tick(vec7(VMAX, VMIN, VMAX, VMIN, VMAX, VMIN, VMAX), 1, 0, 0, STOP_NONE);
		plan_tick(vec7(0, 0, 0, 0, 0, 0, 0), 1, 0, 0, STOP_NONE);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan_q[i]) begin
			if (plan_q[i].kind == ROW_REG) begin
				wait_for_results();
				write_reg(plan_q[i].idx, plan_q[i].val);
			end else begin
				offer_tick(plan_q[i].t, plan_q[i].typed, plan_q[i].typed_status);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			wait_for_results();
			write_reg(REG_LIMIT_PROXIMAL, pick_cfg(0, 32767));
			write_reg(REG_LIMIT_DISTAL, pick_cfg(0, 32767));
			// small ramp steps for the first phases
			write_reg(REG_RAMP_STEP, (p < 3) ? pick_cfg(0, 400) : pick_cfg(0, 65536));
			tmo = $urandom_range(0, 1) ? $urandom_range(1, 6) : pick_cfg(1, 65535);
			write_reg(REG_TIMEOUT_TICKS, tmo);
			write_reg(REG_SMOOTH_WEIGHT, pick_cfg(0, 65536));
			gap_max = (p % 3 == 0) ? 0 : $urandom_range(2, 8);
			rx_quiet = (p % 4 == 1);
			if (p == 2)
				hold_req = 1'b1;
			target_pct = (p % 2 == 0) ? $urandom_range(85, 100) : $urandom_range(40, 80);
			fail_pct = $urandom_range(0, 15);
			for (int k = 0; k < ITEMS_PER_PHASE; k++)
				offer_tick(random_tick(target_pct, fail_pct), 1'b0, STOP_NONE);
		end

		wait_for_results();
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
